### design/kli_pkg.sv
// kli_pkg: types, codes and constants shared by the keyframe interpolator
// controller, datapath and top level
// no dependencies
package kli_pkg;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration registers and port sizing
  localparam int unsigned REG_KEY_COUNT = 0;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned KEY_COUNT_W   = 7;
  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST = 7'd1;

  // fraction divider: one quotient bit per step, weights 2^16 down to 2^0
  localparam int unsigned FRAC_W    = 17;
  localparam int unsigned DIV_STEPS = FRAC_W;
  localparam int unsigned DIV_CNT_W = 5;

  typedef struct packed {
    logic               kind;
    logic        [5:0]  key_index;
    logic        [31:0] key_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic        [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  // one table entry as stored
  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } entry_t;

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z
  } comp_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DINIT,
    ST_DIV,
    ST_SUB,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic  wr_en;
    logic  capture;
    logic  rd_en;
    logic  set_a;
    logic  set_b;
    logic  set_both;
    logic  div_init;
    logic  div_step;
    logic  sub;
    logic  mul;
    logic  add;
    logic  push;
    comp_e comp;
  } cmd_t;

  typedef struct packed {
    logic wr_ok;
    logic qt_le_t0;
    logic bracket;
    logic span_zero;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] comp_of(entry_t e, comp_e c);
    logic [31:0] v;
    case (c)
      COMP_X:  v = e.x;
      COMP_Y:  v = e.y;
      COMP_Z:  v = e.z;
      default: v = e.x;
    endcase
    return v;
  endfunction

endpackage

### design/kli_ctrl.sv
// kli_ctrl: sequencer for table writes, segment scan, fraction divide and
// per-component lerp; drives kli_dp through cmd_t, reads sts_t (kli_pkg)
module kli_ctrl
  import kli_pkg::*;
#(
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  input  logic [IDX_W-1:0] last_idx_i,
  input  sts_t             sts_i,
  output logic             in_stall_o,
  output cmd_t             cmd_o,
  output logic [IDX_W-1:0] rd_addr_o
);

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  comp_e                comp_q, comp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      comp_q  <= COMP_X;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    comp_d     = comp_q;
    cmd_o      = '0;
    cmd_o.comp = comp_q;
    rd_addr_o  = '0;
    in_stall_o = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_QUERY) begin
            cmd_o.capture = 1'b1;
            cmd_o.rd_en   = 1'b1;
            rd_addr_o     = '0;
            state_d       = ST_FIRST;
          end else begin
            cmd_o.wr_en = sts_i.wr_ok;
          end
        end
      end

      ST_FIRST: begin
        // single key in use, or time at or before the first key
        if (last_idx_i == '0 || sts_i.qt_le_t0) begin
          cmd_o.set_both = 1'b1;
          comp_d         = COMP_X;
          state_d        = ST_SUB;
        end else begin
          cmd_o.set_a = 1'b1;
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = IDX_W'(1);
          idx_d       = IDX_W'(1);
          state_d     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (sts_i.bracket) begin
          cmd_o.set_b = 1'b1;
          state_d     = ST_DINIT;
        end else if (idx_q == last_idx_i) begin
          // no bracket found, hold the last key
          cmd_o.set_both = 1'b1;
          comp_d         = COMP_X;
          state_d        = ST_SUB;
        end else begin
          cmd_o.set_a = 1'b1;
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = idx_q + 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end

      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        comp_d         = COMP_X;
        state_d        = sts_i.span_zero ? ST_SUB : ST_DIV;
      end

      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          comp_d  = COMP_X;
          state_d = ST_SUB;
        end
      end

      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_MUL;
      end

      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end

      ST_ADD: begin
        cmd_o.add = 1'b1;
        case (comp_q)
          COMP_X:  begin comp_d = COMP_Y; state_d = ST_SUB; end
          COMP_Y:  begin comp_d = COMP_Z; state_d = ST_SUB; end
          default: begin comp_d = COMP_X; state_d = ST_DONE; end
        endcase
      end

      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### design/kli_dp.sv
// kli_dp: keyframe table memory, segment compare, restoring fraction
// divider, shared multiplier and output register; uses kli_pkg
module kli_dp
  import kli_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned IDX_W    = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_item_t         in_data_i,
  input  cmd_t             cmd_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic             out_stall_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  output out_item_t        out_data_o
);

  entry_t                   mem_q [MAX_KEYS];
  entry_t                   rdata_q;
  entry_t                   a_q;
  entry_t                   b_q;
  logic [31:0]              qt_q;
  logic [32:0]              r_q;
  logic [FRAC_W-1:0]        f_q;
  logic signed [32:0]       diff_q;
  logic signed [FRAC_W+33:0] prod_q;
  out_item_t                res_q;
  out_item_t                out_q;
  logic                     out_valid_q;

  logic [31:0]       kidx32;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wdata;
  logic [31:0]       span;
  logic              r_ge;
  logic [32:0]       r_sel;
  logic [31:0]       a_comp;
  logic [31:0]       b_comp;
  logic [31:0]       sum;

  assign kidx32  = 32'(in_data_i.key_index);
  assign wr_addr = kidx32[IDX_W-1:0];
  assign wdata   = '{t: in_data_i.key_time, x: in_data_i.value_x,
                     y: in_data_i.value_y, z: in_data_i.value_z};

  // table memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // segment endpoints and query time
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      qt_q <= in_data_i.query_time;
    end
    if (cmd_i.set_a || cmd_i.set_both) begin
      a_q <= rdata_q;
    end
    if (cmd_i.set_b || cmd_i.set_both) begin
      b_q <= rdata_q;
    end
  end

  // restoring divide of (qt - t0) * 2^16 by the span
  assign span  = b_q.t - a_q.t;
  assign r_ge  = (r_q >= {1'b0, span});
  assign r_sel = r_ge ? (r_q - {1'b0, span}) : r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_both || cmd_i.div_init) begin
      f_q <= '0;
    end else if (cmd_i.div_step) begin
      f_q <= {f_q[FRAC_W-2:0], r_ge};
    end
    if (cmd_i.div_init) begin
      r_q <= {1'b0, qt_q - a_q.t};
    end else if (cmd_i.div_step) begin
      r_q <= {r_sel[31:0], 1'b0};
    end
  end

  // one component at a time: subtract, multiply, shift and add
  assign a_comp = comp_of(a_q, cmd_i.comp);
  assign b_comp = comp_of(b_q, cmd_i.comp);
  assign sum    = a_comp + prod_q[47:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sub) begin
      diff_q <= $signed({b_comp[31], b_comp}) - $signed({a_comp[31], a_comp});
    end
    if (cmd_i.mul) begin
      prod_q <= diff_q * $signed({1'b0, f_q});
    end
    if (cmd_i.add) begin
      case (cmd_i.comp)
        COMP_X:  res_q.out_x <= sum;
        COMP_Y:  res_q.out_y <= sum;
        COMP_Z:  res_q.out_z <= sum;
        default: res_q.out_x <= sum;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.wr_ok     = (kidx32 < 32'(MAX_KEYS));
  assign sts_o.qt_le_t0  = (qt_q <= rdata_q.t);
  assign sts_o.bracket   = (a_q.t <= qt_q) && (qt_q <= rdata_q.t);
  assign sts_o.span_zero = (span == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

### design/keyframe_linear_interpolator.sv
// keyframe_linear_interpolator: a write beat is taken while idle; a query runs
// a segment scan with one table read per key scanned, 17 divider steps when the
// bracketing segment has nonzero span, and three lerp passes (subtract, multiply,
// add) on one shared multiplier; the next beat can be taken as the result appears.
// one item is in work at a time; a result waits in its output register.
// reset: control and key_count (to 1) clear at once; table undefined until written
module keyframe_linear_interpolator
  import kli_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,

  // item input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,

  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  localparam int unsigned IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  // word index of the addressed register
  localparam int unsigned REG_SEL_W = APB_ADDR_W - 2;

  logic [KEY_COUNT_W-1:0] key_count_q;
  logic [REG_SEL_W-1:0]   reg_sel;
  logic                   cfg_wr;
  logic [31:0]            kc32;
  logic [31:0]            n32;
  logic [31:0]            last32;
  logic [IDX_W-1:0]       last_idx;
  cmd_t                   cmd;
  sts_t                   sts;
  logic [IDX_W-1:0]       rd_addr;

  // apb register file, zero wait states
  assign reg_sel = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KEY_COUNT_RST;
    end else if (cfg_wr && reg_sel == REG_SEL_W'(REG_KEY_COUNT)) begin
      key_count_q <= pwdata[KEY_COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_SEL_W'(REG_KEY_COUNT)) begin
      prdata = APB_DATA_W'(key_count_q);
    end
  end

  // keys in use: zero counts as one, clipped to the table depth
  assign kc32 = 32'(key_count_q);
  always_comb begin
    if (kc32 == '0) begin
      n32 = 32'd1;
    end else if (kc32 > 32'(MAX_KEYS)) begin
      n32 = 32'(MAX_KEYS);
    end else begin
      n32 = kc32;
    end
  end
  assign last32   = n32 - 32'd1;
  assign last_idx = last32[IDX_W-1:0];

  // sequencer
  kli_ctrl #(
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .last_idx_i (last_idx),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  // table, divider, multiplier and output beat register
  kli_dp #(
    .MAX_KEYS (MAX_KEYS),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
